FILE: rtl/drofs_pkg.sv
package drofs_pkg;

    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned BIAS_W     = 12;
    localparam int unsigned DATE_W     = 10;
    localparam int unsigned TIME_W     = 27;
    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned KEY_W      = 37;
    localparam int unsigned OFFSET_W   = 19;

    // yy / 100 == (yy * RECIP_100) >> RECIP_SHIFT, exact for yy < 2**15
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        REG_BASE_BIAS      = 3'd0,
        REG_STD_EXTRA_BIAS = 3'd1,
        REG_DST_EXTRA_BIAS = 3'd2,
        REG_STD_DATE       = 3'd3,
        REG_STD_TIME       = 3'd4,
        REG_DST_DATE       = 3'd5,
        REG_DST_TIME       = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [BIAS_W-1:0] base_bias;
        logic [BIAS_W-1:0] standard_extra_bias;
        logic [BIAS_W-1:0] daylight_extra_bias;
        logic [DATE_W-1:0] std_date;
        logic [TIME_W-1:0] std_time;
        logic [DATE_W-1:0] dst_date;
        logic [TIME_W-1:0] dst_time;
    } cfg_t;

    // Year-dependent terms shared by both rules
    typedef struct packed {
        logic [2:0] g_mar;  // weekday term, months 3..12
        logic [2:0] g_jan;  // weekday term, months 1..2 (previous year)
        logic       leap;
    } year_info_t;

    // Value mod 7: octal digits sum since 8 == 1 mod 7
    function automatic logic [2:0] mod7(input logic [17:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[17:15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    function automatic logic [2:0] month_shift(input logic [3:0] m);
        logic [2:0] r;
        unique case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        month_shift = r;
    endfunction

    function automatic logic [5:0] month_len(input logic [3:0] m, input logic leap);
        logic [5:0] r;
        unique case (m)
            4'd2:                      r = leap ? 6'd29 : 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 6'd30;
            default:                   r = 6'd31;
        endcase
        month_len = r;
    endfunction

endpackage

FILE: rtl/drofs_cfg_regs.sv
module drofs_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drofs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [drofs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [drofs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output drofs_pkg::cfg_t                    cfg
);

    drofs_pkg::cfg_t     cfg_reg;
    drofs_pkg::cfg_t     cfg_next;
    drofs_pkg::reg_idx_t idx;

    assign idx    = drofs_pkg::reg_idx_t'(paddr[drofs_pkg::APB_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                drofs_pkg::REG_BASE_BIAS:
                    cfg_next.base_bias = pwdata[drofs_pkg::BIAS_W-1:0];
                drofs_pkg::REG_STD_EXTRA_BIAS:
                    cfg_next.standard_extra_bias = pwdata[drofs_pkg::BIAS_W-1:0];
                drofs_pkg::REG_DST_EXTRA_BIAS:
                    cfg_next.daylight_extra_bias = pwdata[drofs_pkg::BIAS_W-1:0];
                drofs_pkg::REG_STD_DATE:
                    cfg_next.std_date = pwdata[drofs_pkg::DATE_W-1:0];
                drofs_pkg::REG_STD_TIME:
                    cfg_next.std_time = pwdata[drofs_pkg::TIME_W-1:0];
                drofs_pkg::REG_DST_DATE:
                    cfg_next.dst_date = pwdata[drofs_pkg::DATE_W-1:0];
                drofs_pkg::REG_DST_TIME:
                    cfg_next.dst_time = pwdata[drofs_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            drofs_pkg::REG_BASE_BIAS:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.base_bias);
            drofs_pkg::REG_STD_EXTRA_BIAS:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.standard_extra_bias);
            drofs_pkg::REG_DST_EXTRA_BIAS:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.daylight_extra_bias);
            drofs_pkg::REG_STD_DATE:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.std_date);
            drofs_pkg::REG_STD_TIME:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.std_time);
            drofs_pkg::REG_DST_DATE:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.dst_date);
            drofs_pkg::REG_DST_TIME:
                prdata = drofs_pkg::APB_DATA_W'(cfg_reg.dst_time);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/drofs_rule_day.sv
module drofs_rule_day (
    input  logic [drofs_pkg::DATE_W-1:0] date,
    input  drofs_pkg::year_info_t        yinfo,
    output logic [3:0]                   rule_month,
    output logic [5:0]                   rule_day
);

    logic [2:0] wd;
    logic [2:0] week;
    logic [3:0] m;
    logic [2:0] g;
    logic [3:0] first_sum;
    logic [2:0] first_wd;
    logic [3:0] diff_sum;
    logic [2:0] diff;
    logic [5:0] day_raw;
    logic [5:0] len;

    always_comb
    begin
        wd   = (date[2:0] == 3'd7) ? 3'd0 : date[2:0];
        week = (date[5:3] == 3'd0) ? 3'd1 : ((date[5:3] > 3'd5) ? 3'd5 : date[5:3]);
        m    = (date[9:6] > 4'd12) ? 4'd12 : ((date[9:6] == 4'd0) ? 4'd1 : date[9:6]);
        g    = (m < 4'd3) ? yinfo.g_jan : yinfo.g_mar;

        // weekday of the 1st of the rule month
        first_sum = 4'(g) + 4'(drofs_pkg::month_shift(m)) + 4'd1;
        first_wd  = (first_sum >= 4'd7) ? 3'(first_sum - 4'd7) : first_sum[2:0];

        diff_sum = 4'(wd) + 4'd7 - 4'(first_wd);
        diff     = (diff_sum >= 4'd7) ? 3'(diff_sum - 4'd7) : diff_sum[2:0];

        day_raw = 6'd1 + 6'(diff) + 6'(3'(week - 3'd1)) * 6'd7;
        len     = drofs_pkg::month_len(m, yinfo.leap);

        // last-week rule may overshoot the month end
        rule_day   = (day_raw > len) ? 6'(day_raw - 6'd7) : day_raw;
        rule_month = m;
    end

endmodule

FILE: rtl/dst_rule_offset_evaluator_core.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------------------------------
// item      | item_valid / item_ready    | year month day hour minute second millisecond
// result    | result_valid / result_ready| daylight_active offset_seconds rule_present
// config    | APB psel/penable/pwrite    | paddr pwdata prdata, pready tied high
//
// Five-stage pipeline: one transaction per cycle while the output is not stalled; result_valid
// is the valid bit of the fifth stage, and the result is taken when result_ready is high. The
// stages are year division, weekday/leap, rule dates, key compare with bias select,
// and the offset scaling into the output register.
// rst_n clears the valid bits and the configuration registers.
// A stage holds while its successor is full and stalled; bubbles collapse, so
// item_ready stays high while any stage is empty.
module dst_rule_offset_evaluator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [drofs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [drofs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [drofs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,

    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic [drofs_pkg::YEAR_W-1:0]         year,
    input  logic [3:0]                           month,
    input  logic [4:0]                           day,
    input  logic [4:0]                           hour,
    input  logic [5:0]                           minute,
    input  logic [5:0]                           second,
    input  logic [9:0]                           millisecond,

    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic                                 daylight_active,
    output logic signed [drofs_pkg::OFFSET_W-1:0] offset_seconds,
    output logic                                 rule_present
);

    drofs_pkg::cfg_t cfg;

    drofs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5 = !v5_reg || result_ready;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign item_ready   = ld1;
    assign result_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= item_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: year / 100, ms of day ----------------
    logic [14:0] yy0_next, yy1_next;
    logic [27:0] prod0, prod1;
    logic [26:0] ms_next;
    logic [14:0] yy0_reg, yy1_reg;
    logic [7:0]  q0_reg, q1_reg;
    logic [26:0] ms1_reg;
    logic [3:0]  mon1_reg;
    logic [4:0]  day1_reg;

    always_comb
    begin
        // yy0 for months from March, yy1 for January and February
        yy0_next = 15'(year) + 15'd400;
        yy1_next = 15'(year) + 15'd399;
        prod0    = 28'(yy0_next) * 28'(drofs_pkg::RECIP_100);
        prod1    = 28'(yy1_next) * 28'(drofs_pkg::RECIP_100);
        ms_next  = 27'(hour) * 27'd3600000 + 27'(minute) * 27'd60000
                 + 27'(second) * 27'd1000 + 27'(millisecond);
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            yy0_reg  <= yy0_next;
            yy1_reg  <= yy1_next;
            q0_reg   <= prod0[drofs_pkg::RECIP_SHIFT+7:drofs_pkg::RECIP_SHIFT];
            q1_reg   <= prod1[drofs_pkg::RECIP_SHIFT+7:drofs_pkg::RECIP_SHIFT];
            ms1_reg  <= ms_next;
            mon1_reg <= month;
            day1_reg <= day;
        end
    end

    // ---------------- stage 2: weekday terms, leap year ----------------
    logic [14:0] rem0;
    logic [15:0] gsum0, gsum1;
    drofs_pkg::year_info_t yinfo_next;
    drofs_pkg::year_info_t yinfo_reg;
    logic [26:0] ms2_reg;
    logic [3:0]  mon2_reg;
    logic [4:0]  day2_reg;

    always_comb
    begin
        // yy0 = year + 400 keeps the divisibility of year
        rem0  = yy0_reg - 15'(q0_reg) * 15'd100;
        gsum0 = 16'(yy0_reg) + 16'(yy0_reg[14:2]) - 16'(q0_reg) + 16'(q0_reg[7:2]);
        gsum1 = 16'(yy1_reg) + 16'(yy1_reg[14:2]) - 16'(q1_reg) + 16'(q1_reg[7:2]);
        yinfo_next.g_mar = drofs_pkg::mod7(18'(gsum0));
        yinfo_next.g_jan = drofs_pkg::mod7(18'(gsum1));
        yinfo_next.leap  = ((yy0_reg[1:0] == 2'd0) && (rem0 != 15'd0))
                         || ((rem0 == 15'd0) && (q0_reg[1:0] == 2'd0));
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            yinfo_reg <= yinfo_next;
            ms2_reg   <= ms1_reg;
            mon2_reg  <= mon1_reg;
            day2_reg  <= day1_reg;
        end
    end

    // ---------------- stage 3: transition dates ----------------
    logic [3:0] std_m, dst_m;
    logic [5:0] std_d, dst_d;
    logic [drofs_pkg::KEY_W-1:0] ks_reg, kd_reg, now_reg;
    logic                        rule3_reg;

    drofs_rule_day u_std_day (
        .date       (cfg.std_date),
        .yinfo      (yinfo_reg),
        .rule_month (std_m),
        .rule_day   (std_d)
    );

    drofs_rule_day u_dst_day (
        .date       (cfg.dst_date),
        .yinfo      (yinfo_reg),
        .rule_month (dst_m),
        .rule_day   (dst_d)
    );

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            ks_reg    <= {std_m, std_d, cfg.std_time};
            kd_reg    <= {dst_m, dst_d, cfg.dst_time};
            now_reg   <= {mon2_reg, 1'b0, day2_reg, ms2_reg};
            rule3_reg <= (cfg.std_date[9:6] != 4'd0) && (cfg.dst_date[9:6] != 4'd0);
        end
    end

    // ---------------- stage 4: compare, bias select ----------------
    logic                     dst_next;
    logic                     after_dst, before_std;
    logic [drofs_pkg::BIAS_W-1:0] extra;
    logic signed [12:0]       bias_next;
    logic signed [12:0]       bias_reg;
    logic                     dst4_reg;
    logic                     rule4_reg;

    always_comb
    begin
        after_dst  = (kd_reg <= now_reg);
        before_std = (now_reg < ks_reg);
        if (!rule3_reg)
            dst_next = 1'b0;
        else if (ks_reg < kd_reg)
            dst_next = after_dst || before_std;  // southern hemisphere wrap
        else
            dst_next = after_dst && before_std;
        if (!rule3_reg)
            extra = '0;
        else if (dst_next)
            extra = cfg.daylight_extra_bias;
        else
            extra = cfg.standard_extra_bias;
        bias_next = 13'(signed'(cfg.base_bias)) + 13'(signed'(extra));
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            bias_reg  <= bias_next;
            dst4_reg  <= dst_next;
            rule4_reg <= rule3_reg;
        end
    end

    // ---------------- stage 5: offset = -60 * bias ----------------
    // |bias| <= 4096 keeps the product inside the signed OFFSET_W range, so it cannot overflow
    logic signed [drofs_pkg::OFFSET_W-1:0] b_ext;
    logic signed [drofs_pkg::OFFSET_W-1:0] off_next;
    logic signed [drofs_pkg::OFFSET_W-1:0] off_reg;
    logic                                  dst5_reg;
    logic                                  rule5_reg;

    always_comb
    begin
        b_ext    = drofs_pkg::OFFSET_W'(bias_reg);
        off_next = (b_ext <<< 2) - (b_ext <<< 6);
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            off_reg   <= off_next;
            dst5_reg  <= dst4_reg;
            rule5_reg <= rule4_reg;
        end
    end

    assign daylight_active = dst5_reg;
    assign offset_seconds  = off_reg;
    assign rule_present    = rule5_reg;

endmodule
